/* rtl/core/cbss_pkg.sv */
// Shared widths, word layout and fixed-point helpers for the cubic Bezier segment sampler.
// No dependencies; used by the sampler core, both checkers and the testbench.
package cbss_pkg;

   localparam int COORD_W     = 32;
   localparam int T_W         = 16;
   localparam int IDX_W       = 6;
   localparam int CNT_W       = 7;
   localparam int MAX_SAMPLES = 64;
   localparam int NUM_AXES    = 3;
   localparam int NUM_POINTS  = 4;
   localparam int QUO_W       = 17;
   localparam int DIV_STEPS   = QUO_W;
   localparam int STEP_W      = 5;

   localparam int REQ_DATA_W  = NUM_POINTS * NUM_AXES * COORD_W;
   localparam int IDX_LSB     = NUM_AXES * COORD_W;
   localparam int RSP_DATA_W  = ((IDX_LSB + IDX_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - IDX_LSB - IDX_W;

   typedef logic [NUM_AXES-1:0][COORD_W-1:0] vec_type;

   typedef struct packed {
      logic             vld;
      logic [T_W-1:0]   t;
      logic [IDX_W-1:0] idx;
      logic             last;
   } tag_type;

   // (diff * t) >>> 16 for a signed Q16.16 difference and an unsigned Q0.16 t,
   // kept to 32 bits. Bits below the binary point are dropped, which floors.
   function automatic logic [COORD_W-1:0] lerp_scale(input logic [COORD_W-1:0] diff,
                                                     input logic [T_W-1:0] t);
      logic signed [COORD_W-1:0]     sd;
      logic signed [T_W:0]           st;
      logic signed [COORD_W+T_W:0]   prod;
      sd   = $signed(diff);
      st   = $signed({1'b0, t});
      prod = (COORD_W+T_W+1)'(sd) * (COORD_W+T_W+1)'(st);
      return prod[COORD_W+T_W-1:T_W];
   endfunction

endpackage

/* rtl/core/cubic_bezier_segment_sampler.sv */
// Cubic Bezier segment sampler: a step sequencer feeding a nine-stage de Casteljau pipeline.
// Depends on cbss_pkg for widths, the tag struct and the lerp scaling function.
//
// The points of a segment leave one per cycle while rsp_tready does not stall the
// pipeline. The sequencer issues one t value per cycle, also only while the pipeline
// is not stalled, and takes the next segment after the last one.
// A csr write starts the divider that computes the t step; no segment is taken while it runs.
// Reset (synchronous, active high) empties the pipeline, stops the sequencer and sets
// sample_count to 64.
module cubic_bezier_segment_sampler (
   input  logic                               clock,
   input  logic                               reset,
   // Segment words. req_tdata, low bit up: p0_x p0_y p0_z p1_x p1_y p1_z
   // p2_x p2_y p2_z p3_x p3_y p3_z, 32 bits each.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cbss_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Point words. rsp_tdata, low bit up: out_x, out_y, out_z (32 bits each),
   // sample_index (6 bits), two zero bits. rsp_tlast is last_sample.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cbss_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // sample_count register.
   input  logic                               csr_wr_en,
   input  logic [cbss_pkg::CNT_W-1:0]         csr_wr_data
);

   localparam int CW = cbss_pkg::COORD_W;

   // ---------------------------------------------------------------------
   // sample_count register and the t step divider.
   // t(n) = floor(n * 65536 / count) is stepped by Q = floor(65536 / count)
   // with remainder R, so each sample only needs an add and one compare.
   // Q and R come from a restoring divider, one quotient bit per cycle.
   // ---------------------------------------------------------------------
   logic [cbss_pkg::CNT_W-1:0]  cnt_ff;
   logic [cbss_pkg::CNT_W-1:0]  cnt_in;
   logic                        div_busy_ff;
   logic [cbss_pkg::STEP_W-1:0] div_step_ff;
   logic [cbss_pkg::QUO_W-1:0]  div_quo_ff;
   logic [cbss_pkg::CNT_W-1:0]  div_rem_ff;
   logic [cbss_pkg::CNT_W:0]    div_rem_sh;
   logic                        div_ge;
   logic [cbss_pkg::CNT_W-1:0]  div_rem_in;
   logic [cbss_pkg::QUO_W-1:0]  div_quo_in;

   // A count of zero behaves as one; anything above the maximum saturates.
   always_comb begin
      if (csr_wr_data == '0) begin
         cnt_in = cbss_pkg::CNT_W'(1);
      end else if (csr_wr_data > cbss_pkg::CNT_W'(cbss_pkg::MAX_SAMPLES)) begin
         cnt_in = cbss_pkg::CNT_W'(cbss_pkg::MAX_SAMPLES);
      end else begin
         cnt_in = csr_wr_data;
      end
   end

   // The dividend is 65536: its only set bit enters on the first step.
   assign div_rem_sh = {div_rem_ff, div_step_ff == cbss_pkg::STEP_W'(cbss_pkg::DIV_STEPS - 1)};
   assign div_ge     = div_rem_sh >= {1'b0, cnt_ff};
   assign div_rem_in = div_ge ? cbss_pkg::CNT_W'(div_rem_sh - {1'b0, cnt_ff})
                              : cbss_pkg::CNT_W'(div_rem_sh);
   assign div_quo_in = {div_quo_ff[cbss_pkg::QUO_W-2:0], div_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= cbss_pkg::CNT_W'(cbss_pkg::MAX_SAMPLES);
         div_busy_ff <= 1'b0;
         div_step_ff <= '0;
         div_quo_ff  <= cbss_pkg::QUO_W'(65536 / cbss_pkg::MAX_SAMPLES);
         div_rem_ff  <= cbss_pkg::CNT_W'(65536 % cbss_pkg::MAX_SAMPLES);
      end else if (csr_wr_en) begin
         cnt_ff      <= cnt_in;
         div_busy_ff <= 1'b1;
         div_step_ff <= cbss_pkg::STEP_W'(cbss_pkg::DIV_STEPS - 1);
         div_quo_ff  <= '0;
         div_rem_ff  <= '0;
      end else if (div_busy_ff) begin
         div_quo_ff  <= div_quo_in;
         div_rem_ff  <= div_rem_in;
         div_step_ff <= div_step_ff - cbss_pkg::STEP_W'(1);
         if (div_step_ff == '0) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Segment capture and sample sequencer.
   // The control points are held for the whole segment; each issued sample
   // carries what it needs down the pipeline, so a new segment may be taken
   // while earlier points are still in flight.
   // ---------------------------------------------------------------------
   logic [cbss_pkg::NUM_POINTS-1:0][cbss_pkg::NUM_AXES-1:0][CW-1:0] held_ff;
   logic                        seq_busy_ff;
   logic [cbss_pkg::IDX_W-1:0]  seq_n_ff;
   logic [cbss_pkg::T_W-1:0]    seq_t_ff;
   logic [cbss_pkg::CNT_W-1:0]  seq_frac_ff;
   logic                        seq_last;
   logic [cbss_pkg::CNT_W:0]    frac_sum;
   logic                        frac_carry;
   logic [cbss_pkg::CNT_W-1:0]  seq_frac_in;
   logic [cbss_pkg::T_W-1:0]    seq_t_in;
   logic                        req_fire;
   logic                        adv;
   cbss_pkg::tag_type           issue_tag;

   assign req_tready = !seq_busy_ff && !div_busy_ff;
   assign req_fire   = req_tvalid && req_tready;

   // The whole pipeline moves when the output register is empty or being taken.
   assign adv = !rsp_tvalid || rsp_tready;

   assign seq_last    = ({1'b0, seq_n_ff} + cbss_pkg::CNT_W'(1)) == cnt_ff;
   assign frac_sum    = {1'b0, seq_frac_ff} + {1'b0, div_rem_ff};
   assign frac_carry  = frac_sum >= {1'b0, cnt_ff};
   assign seq_frac_in = frac_carry ? cbss_pkg::CNT_W'(frac_sum - {1'b0, cnt_ff})
                                   : cbss_pkg::CNT_W'(frac_sum);
   assign seq_t_in    = seq_t_ff + div_quo_ff[cbss_pkg::T_W-1:0]
                        + cbss_pkg::T_W'(frac_carry);

   assign issue_tag.vld  = seq_busy_ff;
   assign issue_tag.t    = seq_t_ff;
   assign issue_tag.idx  = seq_n_ff;
   assign issue_tag.last = seq_last;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int p = 0; p < cbss_pkg::NUM_POINTS; p++) begin
            for (int a = 0; a < cbss_pkg::NUM_AXES; a++) begin
               held_ff[p][a] <= req_tdata[(p*cbss_pkg::NUM_AXES + a)*CW +: CW];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_busy_ff <= 1'b0;
         seq_n_ff    <= '0;
         seq_t_ff    <= '0;
         seq_frac_ff <= '0;
      end else if (req_fire) begin
         seq_busy_ff <= 1'b1;
         seq_n_ff    <= '0;
         seq_t_ff    <= '0;
         seq_frac_ff <= '0;
      end else if (seq_busy_ff && adv) begin
         if (seq_last) begin
            seq_busy_ff <= 1'b0;
         end else begin
            seq_n_ff    <= seq_n_ff + cbss_pkg::IDX_W'(1);
            seq_t_ff    <= seq_t_in;
            seq_frac_ff <= seq_frac_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // De Casteljau pipeline. Each level of lerps takes three stages:
   // difference, scale by t, add back to the base point.
   //   level 1: ab, bc, cd   level 2: abc, bcd   level 3: the curve point
   // ---------------------------------------------------------------------
   cbss_pkg::tag_type      l1d_tag_ff, l1m_tag_ff, l1a_tag_ff;
   cbss_pkg::tag_type      l2d_tag_ff, l2m_tag_ff, l2a_tag_ff;
   cbss_pkg::tag_type      l3d_tag_ff, l3m_tag_ff;

   cbss_pkg::vec_type [2:0] l1d_base_ff, l1d_diff_ff, l1m_base_ff, l1m_sh_ff, l1a_pt_ff;
   cbss_pkg::vec_type [1:0] l2d_base_ff, l2d_diff_ff, l2m_base_ff, l2m_sh_ff, l2a_pt_ff;
   cbss_pkg::vec_type       l3d_base_ff, l3d_diff_ff, l3m_base_ff, l3m_sh_ff;

   logic                        rsp_vld_ff;
   cbss_pkg::vec_type           rsp_pt_ff;
   logic [cbss_pkg::IDX_W-1:0]  rsp_idx_ff;
   logic                        rsp_last_ff;

   // Control: valid bits and tags travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         l1d_tag_ff  <= '0;
         l1m_tag_ff  <= '0;
         l1a_tag_ff  <= '0;
         l2d_tag_ff  <= '0;
         l2m_tag_ff  <= '0;
         l2a_tag_ff  <= '0;
         l3d_tag_ff  <= '0;
         l3m_tag_ff  <= '0;
         rsp_vld_ff  <= 1'b0;
         rsp_idx_ff  <= '0;
         rsp_last_ff <= 1'b0;
      end else if (adv) begin
         l1d_tag_ff  <= issue_tag;
         l1m_tag_ff  <= l1d_tag_ff;
         l1a_tag_ff  <= l1m_tag_ff;
         l2d_tag_ff  <= l1a_tag_ff;
         l2m_tag_ff  <= l2d_tag_ff;
         l2a_tag_ff  <= l2m_tag_ff;
         l3d_tag_ff  <= l2a_tag_ff;
         l3m_tag_ff  <= l3d_tag_ff;
         rsp_vld_ff  <= l3m_tag_ff.vld;
         rsp_idx_ff  <= l3m_tag_ff.idx;
         rsp_last_ff <= l3m_tag_ff.last;
      end
   end

   // Datapath, all lanes and axes side by side.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < cbss_pkg::NUM_AXES; a++) begin
            for (int k = 0; k < 3; k++) begin
               l1d_base_ff[k][a] <= held_ff[k][a];
               l1d_diff_ff[k][a] <= held_ff[k+1][a] - held_ff[k][a];
               l1m_base_ff[k][a] <= l1d_base_ff[k][a];
               l1m_sh_ff[k][a]   <= cbss_pkg::lerp_scale(l1d_diff_ff[k][a], l1d_tag_ff.t);
               l1a_pt_ff[k][a]   <= l1m_base_ff[k][a] + l1m_sh_ff[k][a];
            end
            for (int k = 0; k < 2; k++) begin
               l2d_base_ff[k][a] <= l1a_pt_ff[k][a];
               l2d_diff_ff[k][a] <= l1a_pt_ff[k+1][a] - l1a_pt_ff[k][a];
               l2m_base_ff[k][a] <= l2d_base_ff[k][a];
               l2m_sh_ff[k][a]   <= cbss_pkg::lerp_scale(l2d_diff_ff[k][a], l2d_tag_ff.t);
               l2a_pt_ff[k][a]   <= l2m_base_ff[k][a] + l2m_sh_ff[k][a];
            end
            l3d_base_ff[a] <= l2a_pt_ff[0][a];
            l3d_diff_ff[a] <= l2a_pt_ff[1][a] - l2a_pt_ff[0][a];
            l3m_base_ff[a] <= l3d_base_ff[a];
            l3m_sh_ff[a]   <= cbss_pkg::lerp_scale(l3d_diff_ff[a], l3d_tag_ff.t);
            rsp_pt_ff[a]   <= l3m_base_ff[a] + l3m_sh_ff[a];
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{cbss_pkg::RSP_PAD_W{1'b0}}, rsp_idx_ff, rsp_pt_ff};

endmodule

/* rtl/core/cbss_checker.sv */
// Port-level checker for the cubic Bezier segment sampler, bound to the top level.
// Depends on cbss_pkg for the position of sample_index in the point word.
module cbss_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [cbss_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             csr_wr_en
);

   logic [cbss_pkg::IDX_W-1:0] idx;
   assign idx = rsp_tdata[cbss_pkg::IDX_LSB +: cbss_pkg::IDX_W];

   // A stalled point word holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("point word changed while stalled");

   // Within a segment points come back to back with rising index.
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast
      |=> rsp_tvalid && idx == $past(idx) + cbss_pkg::IDX_W'(1))
      else $error("sample index did not step by one");

   // The word after a segment's last point opens a new segment.
   a_idx_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || idx == '0)
      else $error("new segment did not start at sample zero");

   // A taken segment keeps the input closed while its samples are issued.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input open right after a segment was taken");

   // The t step divider keeps the input closed after a register write.
   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_tready)
      else $error("input open during the t step computation");

endmodule

bind cubic_bezier_segment_sampler cbss_checker u_cbss_checker (.*);

/* verif/cbss_point_checker.sv */
// Port checker for the cubic Bezier segment sampler: predicts every curve point of each
// accepted segment word and compares the point words that leave the block.
// Depends on cbss_pkg for widths and the response word layout.
module cbss_point_checker
   import cbss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    rsp_tlast,
   input  logic                    csr_wr_en,
   input  logic [CNT_W-1:0]        csr_wr_data,
   input  logic                    drain_done,
   output int                      mismatch_count,
   output int                      points_pending,
   output int                      segments_seen,
   output int                      points_seen
);

   typedef struct packed {
      vec_type          coord;
      logic [IDX_W-1:0] index;
      logic             last;
   } curve_point_type;

   curve_point_type  expected_points[$];
   logic [CNT_W-1:0] sample_count_reg;
   bit               drain_checked;

   // One interpolation step: a + ((b - a) * t >>> 16), all sums wrapping at 32 bits.
   function automatic logic [COORD_W-1:0] lerp_fixed(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b,
                                                     input logic [T_W-1:0]     t);
      logic [COORD_W-1:0] diff;
      longint             prod;
      diff = b - a;
      prod = longint'($signed(diff)) * longint'(t);
      prod = prod >>> T_W;
      return a + COORD_W'(prod);
   endfunction

   function automatic logic [COORD_W-1:0] casteljau_axis(input logic [COORD_W-1:0] a,
                                                         input logic [COORD_W-1:0] b,
                                                         input logic [COORD_W-1:0] c,
                                                         input logic [COORD_W-1:0] d,
                                                         input logic [T_W-1:0]     t);
      logic [COORD_W-1:0] ab, bc, cd, abc, bcd;
      ab  = lerp_fixed(a, b, t);
      bc  = lerp_fixed(b, c, t);
      cd  = lerp_fixed(c, d, t);
      abc = lerp_fixed(ab, bc, t);
      bcd = lerp_fixed(bc, cd, t);
      return lerp_fixed(abc, bcd, t);
   endfunction

   task automatic predict_segment(input logic [REQ_DATA_W-1:0] seg);
      logic [COORD_W-1:0] held [NUM_POINTS*NUM_AXES];
      logic [T_W-1:0]     t;
      curve_point_type    pt;
      int                 count;
      count = int'(sample_count_reg);
      // A count of zero still gives one point; counts above the maximum saturate.
      if (count < 1) count = 1;
      if (count > MAX_SAMPLES) count = MAX_SAMPLES;
      for (int i = 0; i < NUM_POINTS*NUM_AXES; i++) held[i] = seg[i*COORD_W +: COORD_W];
      for (int n = 0; n < count; n++) begin
         t = T_W'((n * 65536) / count);
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            pt.coord[ax] = casteljau_axis(held[ax], held[3+ax], held[6+ax], held[9+ax], t);
         end
         pt.index = IDX_W'(n);
         pt.last  = (n == count - 1);
         expected_points = {expected_points, pt};
      end
   endtask

   task automatic report_mismatch(input string what, input logic [COORD_W-1:0] want,
                                  input logic [COORD_W-1:0] got);
      mismatch_count++;
      $display("%0t: point check failed on %s: expected %h, got %h", $time, what, want, got);
   endtask

   task automatic check_point();
      curve_point_type    want;
      logic [COORD_W-1:0] got;
      if (expected_points.size() == 0) begin
         report_mismatch("word with no point pending", '0, rsp_tdata[COORD_W-1:0]);
      end else begin
         want = expected_points.pop_front();
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            got = rsp_tdata[ax*COORD_W +: COORD_W];
            if (got !== want.coord[ax])
               report_mismatch($sformatf("axis %0d of sample %0d", ax, want.index),
                               want.coord[ax], got);
         end
         if (rsp_tdata[IDX_LSB +: IDX_W] !== want.index)
            report_mismatch("sample_index", COORD_W'(want.index),
                            COORD_W'(rsp_tdata[IDX_LSB +: IDX_W]));
         if (rsp_tlast !== want.last)
            report_mismatch($sformatf("last_sample of sample %0d", want.index),
                            COORD_W'(want.last), COORD_W'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_points.delete();
         sample_count_reg = CNT_W'(MAX_SAMPLES);
         mismatch_count   = 0;
         drain_checked    = 0;
         segments_seen    = 0;
         points_seen      = 0;
      end else begin
         if (csr_wr_en) sample_count_reg = csr_wr_data;
         if (req_tvalid && req_tready) begin
            predict_segment(req_tdata);
            segments_seen++;
         end
         if (rsp_tvalid && rsp_tready) begin
            check_point();
            points_seen++;
         end
         if (drain_done && !drain_checked) begin
            drain_checked = 1;
            if (expected_points.size() != 0)
               report_mismatch("points never delivered", '0,
                               COORD_W'(expected_points.size()));
         end
      end
      points_pending = expected_points.size();
   end

endmodule

/* verif/tb_cubic_bezier_segment_sampler.sv */
// Top-level testbench for the cubic Bezier segment sampler: clock, reset, segment and
// sample_count stimulus, a stalling point receiver, and the final verdict.
// Depends on cbss_pkg, the sampler RTL and cbss_point_checker.
module tb_cubic_bezier_segment_sampler;
   import cbss_pkg::*;

   // The receiver switches between these back-pressure patterns in stretches.
   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_PERIODIC
   } ready_mode_type;

   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 26;
   localparam int SETTLE_CYCLES    = 20;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_wr_en;
   logic [CNT_W-1:0]        csr_wr_data;
   logic                    drain_done;

   int mismatch_count;
   int points_pending;
   int segments_seen;
   int points_seen;
   int settings_written;

   cubic_bezier_segment_sampler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // The checker sees every handshake on both channels and every register write, and
   // keeps its own copy of sample_count to know how many points each segment gives.
   cbss_point_checker u_point_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .drain_done     (drain_done),
      .mismatch_count (mismatch_count),
      .points_pending (points_pending),
      .segments_seen  (segments_seen),
      .points_seen    (points_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A coordinate drawn from a mix of classes: fully random words, small values around
   // the origin, the signed extremes, zero and all ones, walking ones and zeros, and whole numbers.
   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return COORD_W'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
         6: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return '0;
               default: return '1;
            endcase
         end
         7:       return 32'h1 << $urandom_range(0, 31);
         8:       return ~(32'h1 << $urandom_range(0, 31));
         default: return {16'($urandom_range(0, 65535)), 16'h0};
      endcase
   endfunction

   // Builds a segment word from four control values: x takes each value as it is, y its
   // complement and z its halves swapped, so all three axes see different curves.
   function automatic logic [REQ_DATA_W-1:0] segment_from_points(input logic [COORD_W-1:0] p0,
                                                                 input logic [COORD_W-1:0] p1,
                                                                 input logic [COORD_W-1:0] p2,
                                                                 input logic [COORD_W-1:0] p3);
      logic [COORD_W-1:0]    pts [NUM_POINTS];
      logic [REQ_DATA_W-1:0] seg;
      pts = '{p0, p1, p2, p3};
      for (int k = 0; k < NUM_POINTS; k++) begin
         seg[(3*k)*COORD_W     +: COORD_W] = pts[k];
         seg[(3*k + 1)*COORD_W +: COORD_W] = ~pts[k];
         seg[(3*k + 2)*COORD_W +: COORD_W] = {pts[k][15:0], pts[k][31:16]};
      end
      return seg;
   endfunction

   // Most of the twelve coordinates of a random segment are drawn independently. The rest
   // are small offsets around one base point, the shape a real path would have.
   function automatic logic [REQ_DATA_W-1:0] random_segment();
      logic [REQ_DATA_W-1:0] seg;
      logic [COORD_W-1:0]    base;
      base = pick_coord();
      for (int i = 0; i < NUM_POINTS*NUM_AXES; i++) begin
         if ($urandom_range(0, 4) != 0)
            seg[i*COORD_W +: COORD_W] = pick_coord();
         else
            seg[i*COORD_W +: COORD_W] = base + COORD_W'($urandom_range(0, 32'h0003_FFFF))
                                        - 32'h0002_0000;
      end
      return seg;
   endfunction

   // Mostly short segments keep the run fast; the extremes and the out-of-range values
   // that the block must clamp still come up regularly.
   function automatic logic [CNT_W-1:0] pick_sample_count();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return CNT_W'($urandom_range(1, 16));
      if (r < 8) return CNT_W'($urandom_range(17, MAX_SAMPLES));
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return CNT_W'(MAX_SAMPLES);
         2:       return '1;
         default: return CNT_W'($urandom_range(MAX_SAMPLES + 1, 127));
      endcase
   endfunction

   // Presents one segment word from the next falling edge and holds it until the
   // block takes it. Returns right after the accepting rising edge.
   task automatic send_segment(input logic [REQ_DATA_W-1:0] seg);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = seg;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drops valid and waits until every predicted point has come out, then lets the
   // pipeline settle. Returns at a falling edge.
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (points_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register writes only happen with the block idle.
   task automatic set_sample_count(input logic [CNT_W-1:0] value);
      wait_for_drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      settings_written++;
   endtask

   // Point receiver: each stretch picks a back-pressure pattern at random, including
   // stretches where it never stalls.
   initial begin
      ready_mode_type mode;
      int             stretch;
      rsp_tready = 1'b0;
      forever begin
         mode    = ready_mode_type'($urandom_range(0, 3));
         stretch = $urandom_range(20, 200);
         for (int k = 0; k < stretch; k++) begin
            @(negedge clock);
            case (mode)
               READY_ALWAYS: rsp_tready = 1'b1;
               READY_MOSTLY: rsp_tready = ($urandom_range(0, 9) < 7);
               READY_RARELY: rsp_tready = ($urandom_range(0, 9) < 3);
               default:      rsp_tready = ((k % 7) >= 3);
            endcase
         end
      end
   end

   // Main stimulus.
   initial begin
      int burst_left;
      int gap;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      drain_done       = 1'b0;
      settings_written = 0;
      burst_left       = 0;

      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed segments at the reset count of 64: all zero, the signed extremes,
      // control points that swing between the extremes so the x and y differences wrap,
      // alternating bit patterns and a straight line along the axes.
      send_segment('0);
      send_segment(segment_from_points(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_segment(segment_from_points(32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 32'h8000_0000));
      send_segment(segment_from_points(32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFF));
      send_segment(segment_from_points(32'h7FFF_FFFF, 32'h8000_0000,
                                       32'h7FFF_FFFF, 32'h8000_0000));
      send_segment(segment_from_points(32'hAAAA_AAAA, 32'h5555_5555,
                                       32'hFFFF_FFFF, 32'h0000_0001));
      send_segment(segment_from_points(32'h0000_0000, 32'h0001_0000,
                                       32'h0002_0000, 32'h0003_0000));

      // A count of zero behaves as one: a single point equal to p0, flagged last.
      set_sample_count('0);
      send_segment(random_segment());
      send_segment(segment_from_points('1, 32'h8000_0000, 32'h7FFF_FFFF, '0));

      // The smallest legal count.
      set_sample_count(CNT_W'(1));
      send_segment(random_segment());
      send_segment(random_segment());

      // Counts above the maximum must saturate to 64 points.
      set_sample_count('1);
      send_segment(random_segment());
      send_segment(segment_from_points(32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'h7FFF_FFFF));
      set_sample_count(CNT_W'(MAX_SAMPLES + 1));
      send_segment(random_segment());

      // A count that does not divide 65536, so the t values after the first are rounded down.
      set_sample_count(CNT_W'(3));
      send_segment(random_segment());
      send_segment(random_segment());

      // Random phases. The sender works in bursts of random length; most bursts are
      // preceded by an idle gap, the rest follow straight on from the previous one.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_sample_count(pick_sample_count());
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 2) != 0) begin
                  gap = $urandom_range(1, 12);
                  @(negedge clock);
                  req_tvalid = 1'b0;
                  repeat (gap - 1) @(negedge clock);
               end
            end
            send_segment(random_segment());
            burst_left--;
         end
      end

      // Let the last points out, then ask the checker to flag anything still owed.
      wait_for_drain();
      drain_done = 1'b1;
      repeat (2) @(negedge clock);

      $display("Run covered %0d segments and %0d curve points over %0d sample_count writes,",
               segments_seen, points_seen, settings_written);
      $display("including a zero count, a count of one, 64 and counts above the maximum.");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run, even with the receiver stalling hard.
   initial begin
      #10_000_000;
      $display("Timeout with %0d points still pending.", points_pending);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

/* files.f */
rtl/core/cbss_pkg.sv
rtl/core/cubic_bezier_segment_sampler.sv
rtl/core/cbss_checker.sv
verif/cbss_point_checker.sv
verif/tb_cubic_bezier_segment_sampler.sv
